>>> rtl/exponential_search_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Exponential search engine - assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_SEARCH_ENGINE_UNIT_DEFINES_SVH
`define EXPONENTIAL_SEARCH_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define ESE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ESE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ese_pkg.sv
// ----------------------------------------------------------------------------
// Exponential search engine - package
// Operation codes, microcode layout and the microprogram ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package ese_pkg;

    localparam int unsigned DEPTH_DEF = 1024;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned OP_W      = 2;

    // Operation codes on the input channel
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Microprogram step addresses
    typedef logic [2:0] step_t;
    localparam step_t ST_IDLE   = 3'd0;
    localparam step_t ST_APPEND = 3'd1;
    localparam step_t ST_SINIT  = 3'd2;
    localparam step_t ST_GALLOP = 3'd3;
    localparam step_t ST_MID    = 3'd4;
    localparam step_t ST_CMP    = 3'd5;
    localparam step_t ST_FOUND  = 3'd6;
    localparam step_t ST_MISS   = 3'd7;

    // Sequencer jump kinds
    typedef logic [2:0] jmp_t;
    localparam jmp_t J_DISPATCH = 3'd0; // wait for a beat, branch on operation
    localparam jmp_t J_OUT      = 3'd1; // hold until output slot free, then tgt
    localparam jmp_t J_EMPTY    = 3'd2; // empty table ? tgt : next
    localparam jmp_t J_GALLOP   = 3'd3; // keep galloping ? tgt : next
    localparam jmp_t J_BSEND    = 3'd4; // bracket empty ? tgt : next
    localparam jmp_t J_HIT      = 3'd5; // match ? next : tgt

    // Datapath operations
    typedef logic [2:0] dop_t;
    localparam dop_t D_NONE   = 3'd0;
    localparam dop_t D_APPEND = 3'd1;
    localparam dop_t D_SINIT  = 3'd2;
    localparam dop_t D_GALLOP = 3'd3;
    localparam dop_t D_MID    = 3'd4;
    localparam dop_t D_CMP    = 3'd5;
    localparam dop_t D_FOUND  = 3'd6;
    localparam dop_t D_MISS   = 3'd7;

    typedef struct packed {
        jmp_t  jmp;
        step_t tgt;
        dop_t  dop;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        logic accept;
        dop_t dop;
    } ese_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic empty;
        logic gal_more;
        logic bs_done;
        logic hit;
        logic out_free;
    } ese_stat_t;

    // Microprogram ROM
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            ST_IDLE:   w = '{jmp: J_DISPATCH, tgt: ST_IDLE,   dop: D_NONE};
            ST_APPEND: w = '{jmp: J_OUT,      tgt: ST_IDLE,   dop: D_APPEND};
            ST_SINIT:  w = '{jmp: J_EMPTY,    tgt: ST_MISS,   dop: D_SINIT};
            ST_GALLOP: w = '{jmp: J_GALLOP,   tgt: ST_GALLOP, dop: D_GALLOP};
            ST_MID:    w = '{jmp: J_BSEND,    tgt: ST_MISS,   dop: D_MID};
            ST_CMP:    w = '{jmp: J_HIT,      tgt: ST_MID,    dop: D_CMP};
            ST_FOUND:  w = '{jmp: J_OUT,      tgt: ST_IDLE,   dop: D_FOUND};
            ST_MISS:   w = '{jmp: J_OUT,      tgt: ST_IDLE,   dop: D_MISS};
            default:   w = '{jmp: J_DISPATCH, tgt: ST_IDLE,   dop: D_NONE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/exponential_search_engine_unit.sv
// ----------------------------------------------------------------------------
// Exponential search engine - top level
// Sorted-table store with gallop-then-bisect lookup, microcoded control.
// ----------------------------------------------------------------------------
// Input beats carry s_operation and s_value: clear empties the table and
// gives no result, append writes the next entry, search looks up s_value.
// Append and search each give one result beat (m_found, m_position,
// m_overflow); an unused operation code is dropped without a result.
// One item is worked on at a time: s_ready is high only while the sequencer
// sits in its idle step. A search runs gallop probes (one per cycle), then
// bisection probes (each an address step, then the registered RAM read comes
// back and is compared), and ends in a hit or a miss step; an empty table
// goes straight to the miss step. The table RAM has a single read port, so
// the probes run one after another.
// Results sit in an output register; if the receiver stalls, the sequencer
// holds in its emit step until the slot frees, so no result is lost.
// Reset empties the table and clears the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module exponential_search_engine_unit #(
    parameter int unsigned DEPTH = ese_pkg::DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [ese_pkg::OP_W-1:0]         s_operation,
    input  wire logic signed [ese_pkg::VAL_W-1:0] s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_found,
    output logic [ese_pkg::POS_W-1:0]             m_position,
    output logic                                  m_overflow
);
    import ese_pkg::*;

    ese_ctrl_t ctrl;
    ese_stat_t stat;

    // microcode sequencer
    ese_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .stat        (stat),
        .s_ready     (s_ready),
        .ctrl        (ctrl)
    );

    // datapath with table RAM
    ese_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_ready     (m_ready),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_found     (m_found),
        .m_position  (m_position),
        .m_overflow  (m_overflow)
    );

endmodule

`default_nettype wire

>>> rtl/ese_ram.sv
// ----------------------------------------------------------------------------
// Exponential search engine - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/ese_seq.sv
// ----------------------------------------------------------------------------
// Exponential search engine - microcode sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_seq (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    input  wire logic [ese_pkg::OP_W-1:0]  s_operation,
    input  wire ese_pkg::ese_stat_t        stat,
    output logic                           s_ready,
    output ese_pkg::ese_ctrl_t             ctrl
);
    import ese_pkg::*;

    step_t  upc_reg;
    step_t  upc_next;
    step_t  upc_inc;
    uword_t uw;
    logic   accept;

    assign uw      = ucode(upc_reg);
    assign upc_inc = step_t'(upc_reg + 3'd1);
    assign s_ready = (uw.jmp == J_DISPATCH);
    assign accept  = s_ready & s_valid;

    assign ctrl.accept = accept;
    assign ctrl.dop    = uw.dop;

    // next step select
    always_comb begin
        case (uw.jmp)
            J_DISPATCH: begin
                upc_next = ST_IDLE;
                if (accept) begin
                    case (s_operation)
                        OP_APPEND: upc_next = ST_APPEND;
                        OP_SEARCH: upc_next = ST_SINIT;
                        default:   upc_next = ST_IDLE;
                    endcase
                end
            end
            J_OUT:    upc_next = stat.out_free ? uw.tgt : upc_reg;
            J_EMPTY:  upc_next = stat.empty    ? uw.tgt : upc_inc;
            J_GALLOP: upc_next = stat.gal_more ? uw.tgt : upc_inc;
            J_BSEND:  upc_next = stat.bs_done  ? uw.tgt : upc_inc;
            J_HIT:    upc_next = stat.hit      ? upc_inc : uw.tgt;
            default:  upc_next = ST_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ese_dp.sv
// ----------------------------------------------------------------------------
// Exponential search engine - datapath
// Table RAM, entry count, search bounds, compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_dp #(
    parameter int unsigned DEPTH = ese_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ese_pkg::ese_ctrl_t            ctrl,
    input  wire logic [ese_pkg::OP_W-1:0]      s_operation,
    input  wire logic signed [ese_pkg::VAL_W-1:0] s_value,
    input  wire logic                          m_ready,
    output ese_pkg::ese_stat_t                 stat,
    output logic                               m_valid,
    output logic                               m_found,
    output logic [ese_pkg::POS_W-1:0]          m_position,
    output logic                               m_overflow
);
    import ese_pkg::*;

    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned IDXW = $clog2(DEPTH);
    localparam int unsigned PW   = CW + 2;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [VAL_W-1:0]  target_reg;
    logic signed [PW-1:0]     lo_reg;
    logic signed [PW-1:0]     hi_reg;
    logic [IDXW-1:0]          mid_reg;
    logic                     found_reg;
    logic [POS_W-1:0]         pos_reg;
    logic                     ovf_reg;

    logic [VAL_W-1:0]         rd_data;
    logic signed [VAL_W-1:0]  rd_val;
    logic [IDXW-1:0]          rd_addr;
    logic                     wr_en;
    logic signed [PW-1:0]     last_s;
    logic signed [PW-1:0]     hi2;
    logic signed [PW-1:0]     mid_c;
    logic signed [PW-1:0]     mid_s;
    logic                     lt;
    logic                     eq;
    logic                     full;
    logic                     out_free;

    // table storage
    ese_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (count_reg[IDXW-1:0]),
        .wdata (target_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // compare and bound arithmetic
    assign rd_val   = $signed(rd_data);
    assign lt       = rd_val < target_reg;
    assign eq       = rd_val == target_reg;
    assign last_s   = $signed({2'b00, count_reg}) - $signed(PW'(1));
    assign hi2      = hi_reg <<< 1;
    assign mid_c    = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign mid_s    = $signed({(PW - IDXW)'(0), mid_reg});
    assign full     = (count_reg == CW'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign wr_en    = (ctrl.dop == D_APPEND) && out_free && !full;

    // read address per step; the read data is registered in the RAM
    always_comb begin
        case (ctrl.dop)
            D_GALLOP: rd_addr = hi2[IDXW-1:0];
            D_MID:    rd_addr = mid_c[IDXW-1:0];
            default:  rd_addr = '0;
        endcase
    end

    // status back to the sequencer
    assign stat.empty    = (count_reg == '0);
    assign stat.gal_more = lt && (hi2 < last_s);
    assign stat.bs_done  = lo_reg > hi_reg;
    assign stat.hit      = eq;
    assign stat.out_free = out_free;

    // control state: entry count and output valid
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (ctrl.accept && (s_operation == OP_CLEAR)) begin
            count_next = '0;
        end
        case (ctrl.dop)
            D_APPEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (!full) begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            D_FOUND, D_MISS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers and result payload
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            target_reg <= s_value;
        end
        case (ctrl.dop)
            D_APPEND: begin
                if (out_free) begin
                    found_reg <= 1'b0;
                    pos_reg   <= '0;
                    ovf_reg   <= full;
                end
            end
            D_SINIT: begin
                lo_reg <= '0;
                hi_reg <= (count_reg >= CW'(2)) ? PW'(1) : PW'(0);
            end
            D_GALLOP: begin
                if (lt) begin
                    lo_reg <= hi_reg;
                    hi_reg <= (hi2 >= last_s) ? last_s : hi2;
                end
            end
            D_MID: begin
                mid_reg <= mid_c[IDXW-1:0];
            end
            D_CMP: begin
                if (!eq) begin
                    if (target_reg > rd_val) begin
                        lo_reg <= mid_s + PW'(1);
                    end else begin
                        hi_reg <= mid_s - PW'(1);
                    end
                end
            end
            D_FOUND: begin
                if (out_free) begin
                    found_reg <= 1'b1;
                    pos_reg   <= POS_W'(mid_reg);
                    ovf_reg   <= 1'b0;
                end
            end
            D_MISS: begin
                if (out_free) begin
                    found_reg <= 1'b0;
                    pos_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = found_reg;
    assign m_position = pos_reg;
    assign m_overflow = ovf_reg;

endmodule

`default_nettype wire

>>> rtl/ese_checker.sv
// ----------------------------------------------------------------------------
// Exponential search engine - port checker
// Watches the top-level ports over time; bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "exponential_search_engine_unit_defines.svh"

module ese_checker (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic [ese_pkg::OP_W-1:0] s_operation,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic                     m_found,
    input wire logic [ese_pkg::POS_W-1:0] m_position,
    input wire logic                     m_overflow
);
    import ese_pkg::*;

    // stalled result beat holds
    `ESE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_found) && $stable(m_position) && $stable(m_overflow), "result beat changed while stalled")

    // a hit is never an overflow
    `ESE_ASSERT_SAME(a_found_no_ovf, aclk, aresetn, m_valid && m_found, !m_overflow, "found and overflow both set")

    // a miss or append reports position zero
    `ESE_ASSERT_SAME(a_miss_pos, aclk, aresetn, m_valid && !m_found, m_position == '0, "non-zero position without a hit")

    // a search beat occupies the engine for at least the next cycle
    `ESE_ASSERT_NEXT(a_search_busy, aclk, aresetn, s_valid && s_ready && (s_operation == OP_SEARCH), !s_ready, "ready straight after a search beat")

endmodule

bind exponential_search_engine_unit ese_checker u_ese_checker (.*);

`default_nettype wire

>>> tb/tb_exponential_search_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential search engine - regression testbench
// Drives clear, append and search beats into the engine with random gaps and
// result stalls. A scoreboard keeps its own copy of the table and predicts
// each result. Stimulus covers directed corners, one large table searched
// across its span, and random episodes of sorted, duplicate-heavy and
// unsorted tables.
// ----------------------------------------------------------------------------

// Scoreboard: own copy of the table, predicted results in beat order
class table_scoreboard;

    typedef struct packed {
        logic                     found;
        logic [ese_pkg::POS_W-1:0] position;
        logic                     overflow;
    } lookup_result_t;

    logic signed [ese_pkg::VAL_W-1:0] entries [ese_pkg::DEPTH_DEF];
    int             fill;
    lookup_result_t awaited_results [$];

    int errors;
    int reported;
    int n_append, n_dropped, n_search, n_hit, n_clear, n_unused, n_checked;

    function new();
        fill     = 0;
        errors   = 0;
        reported = 0;
        n_append = 0; n_dropped = 0; n_search = 0; n_hit = 0;
        n_clear  = 0; n_unused  = 0; n_checked = 0;
    endfunction

    // Gallop then bisect; returns -1 on a miss
    function int predict_position(logic signed [ese_pkg::VAL_W-1:0] target);
        int last, lo, hi, probe, mid;
        if (fill == 0) return -1;
        last  = fill - 1;
        lo    = 0;
        hi    = (last < 1) ? last : 1;
        probe = 0;
        while (entries[probe] < target) begin
            lo = hi;
            hi = 2 * hi;
            // clamp at the table end, galloping stops there
            if (hi >= last) begin
                hi = last;
                break;
            end
            probe = hi;
        end
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] == target) return mid;
            if (target > entries[mid]) lo = mid + 1;
            else                       hi = mid - 1;
        end
        return -1;
    endfunction

    // Accepted input beat: update the table copy, queue any result
    function void note_input(logic [ese_pkg::OP_W-1:0] op,
                             logic signed [ese_pkg::VAL_W-1:0] val);
        lookup_result_t r;
        int             hit;
        r = '0;
        case (op)
            ese_pkg::OP_CLEAR: begin
                fill = 0;
                n_clear++;
            end
            ese_pkg::OP_APPEND: begin
                n_append++;
                if (fill < ese_pkg::DEPTH_DEF) begin
                    entries[fill] = val;
                    fill++;
                end else begin
                    r.overflow = 1'b1;
                    n_dropped++;
                end
                awaited_results.push_back(r);
            end
            ese_pkg::OP_SEARCH: begin
                n_search++;
                hit = predict_position(val);
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = hit[ese_pkg::POS_W-1:0];
                    n_hit++;
                end
                awaited_results.push_back(r);
            end
            default: n_unused++;   // unused code, dropped by the engine
        endcase
    endfunction

    function void note_mismatch(string msg);
        errors++;
        if (reported < 10) begin
            reported++;
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // Result beat: compare with the oldest prediction
    function void check_result(logic f, logic [ese_pkg::POS_W-1:0] p, logic o);
        lookup_result_t want;
        if (awaited_results.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing awaited: found=%0d pos=%0d ovf=%0d",
                                    f, p, o));
            return;
        end
        want = awaited_results.pop_front();
        n_checked++;
        if (f !== want.found || p !== want.position || o !== want.overflow)
            note_mismatch($sformatf("mismatch: found %0d/%0d pos %0d/%0d ovf %0d/%0d (exp/act)",
                                    want.found, f, want.position, p, want.overflow, o));
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

endclass

module tb_exponential_search_engine_unit;

    import ese_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int              ITEMS_TARGET = 650;
    localparam int              LARGE_N      = 300;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [OP_W-1:0]         s_operation;
    logic signed [VAL_W-1:0] s_value;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_found;
    logic [POS_W-1:0]        m_position;
    logic                    m_overflow;

    table_scoreboard sb;

    // Idle/stall chance in percent, shared by both sides
    int idle_pct;
    bit quiet;
    int sent_items;

    // Working set of values for one episode
    logic signed [VAL_W-1:0] batch [0:DEPTH_DEF-1];

    exponential_search_engine_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_position  (m_position),
        .m_overflow  (m_overflow)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("exponential_search_engine_unit regression: fail");
        $finish;
    end

    // Receiver: random stall bursts
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_found, m_position, m_overflow);
    end

    // Count sent beats; idling stops for the last stretch
    function automatic void count_item();
        sent_items++;
        if (sent_items >= ITEMS_TARGET - 60) quiet = 1'b1;
    endfunction

    // Send one beat, with an optional idle burst in front
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, val);
        count_item();
    endtask

    // Random value: extremes, values near zero, or any 32-bit pattern
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            2:       v = $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
            3, 4, 5: v = $signed($urandom_range(0, 200)) - 100;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Insertion sort on the first n entries of the batch
    function automatic void sort_batch(int n);
        int i, j;
        logic signed [VAL_W-1:0] v;
        for (i = 1; i < n; i++) begin
            v = batch[i];
            j = i - 1;
            while (j >= 0 && batch[j] > v) begin
                batch[j + 1] = batch[j];
                j--;
            end
            batch[j + 1] = v;
        end
    endfunction

    // Search target: mostly present entries, some neighbours, some anything
    function automatic logic signed [VAL_W-1:0] pick_target(int n);
        int r, j;
        r = $urandom_range(0, 9);
        if (n == 0 || r < 2) return pick_value();
        j = $urandom_range(0, n - 1);
        if (r < 7) return batch[j];
        if (r == 7) return batch[j] + 1;
        if (r == 8) return batch[j] - 1;
        return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    endfunction

    // One random episode: clear, load a table, search it
    task automatic run_episode();
        int mode, k, n_find, i;
        mode = $urandom_range(0, 19);    // <15 sorted, 15-16 duplicates, else unsorted
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        // keep the run near its item budget
        if (k > ITEMS_TARGET - sent_items) k = ITEMS_TARGET - sent_items;
        case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 40;
        endcase
        send_item(OP_CLEAR, $urandom);
        for (i = 0; i < k; i++)
            batch[i] = (mode == 15 || mode == 16) ?
                       $signed($urandom_range(0, 5)) * 1000 - 2000 : pick_value();
        if (mode < 17) sort_batch(k);
        for (i = 0; i < k; i++) begin
            if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, $urandom);
            send_item(OP_APPEND, batch[i]);
        end
        n_find = $urandom_range(1, 12) + ((k / 4 > 18) ? 18 : k / 4);
        for (i = 0; i < n_find; i++) begin
            send_item(OP_SEARCH, pick_target(k));
            // now and then a stray append breaks the ordering
            if ($urandom_range(0, 24) == 0) begin
                send_item(OP_APPEND, pick_value());
            end
        end
    endtask

    // Main sequence
    initial begin : stimulus
        int i;
        sb          = new();
        idle_pct    = 20;
        quiet       = 1'b0;
        sent_items  = 0;
        s_valid     = 1'b0;
        s_operation = OP_CLEAR;
        s_value     = '0;
        aresetn     = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, unused code, extremes
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_UNUSED, VAL_MAX);
        send_item(OP_APPEND, VAL_MIN);
        send_item(OP_APPEND, -32'sd1);
        send_item(OP_APPEND, 32'sd0);
        send_item(OP_APPEND, 32'sd5);
        send_item(OP_APPEND, VAL_MAX);
        send_item(OP_SEARCH, VAL_MIN);
        send_item(OP_SEARCH, VAL_MAX);
        send_item(OP_SEARCH, -32'sd1);
        send_item(OP_SEARCH, 32'sd5);
        send_item(OP_SEARCH, 32'sd3);
        // Cleared table searches as empty
        send_item(OP_CLEAR, 32'sd0);
        send_item(OP_SEARCH, VAL_MIN);
        // Single entry
        send_item(OP_APPEND, 32'sd7);
        send_item(OP_SEARCH, 32'sd7);
        send_item(OP_SEARCH, 32'sd8);
        send_item(OP_SEARCH, 32'sd6);
        // Unsorted table
        send_item(OP_CLEAR, VAL_MAX);
        send_item(OP_APPEND, 32'sd9);
        send_item(OP_APPEND, 32'sd1);
        send_item(OP_APPEND, 32'sd5);
        send_item(OP_SEARCH, 32'sd1);
        // Duplicates
        send_item(OP_CLEAR, 32'sd0);
        for (i = 0; i < 4; i++) send_item(OP_APPEND, 32'sd4);
        send_item(OP_SEARCH, 32'sd4);

        // Large table: long gallops that clamp at the end, searches across the span
        idle_pct = 10;
        send_item(OP_CLEAR, 32'sd0);
        for (i = 0; i < LARGE_N; i++) begin
            batch[i] = VAL_MIN + i * 4194304 + $signed($urandom_range(0, 100));
            send_item(OP_APPEND, batch[i]);
        end
        send_item(OP_SEARCH, batch[0]);
        send_item(OP_SEARCH, batch[LARGE_N - 1]);
        send_item(OP_SEARCH, batch[LARGE_N / 2]);
        send_item(OP_SEARCH, VAL_MAX);
        send_item(OP_SEARCH, VAL_MIN);
        for (i = 0; i < 20; i++) send_item(OP_SEARCH, pick_target(LARGE_N));
        send_item(OP_APPEND, 32'sd0);

        // Random episodes, idling switched off near the end
        while (sent_items < ITEMS_TARGET) run_episode();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("covered %0d appends (%0d dropped on a full table), %0d searches (%0d hits),",
                 sb.n_append, sb.n_dropped, sb.n_search, sb.n_hit);
        $display("%0d clears, %0d unused codes; %0d results checked, %0d mismatches",
                 sb.n_clear, sb.n_unused, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("exponential_search_engine_unit regression: pass");
        end else begin
            $display("exponential_search_engine_unit regression: fail");
        end
        $finish;
    end

endmodule
